// File: rtl/core/cs420_pkg.sv
`default_nettype none

package cs420_pkg;

    localparam int BYTE_W    = 8;
    localparam int SUM_W     = 9;
    localparam int LINE_W    = 2 * SUM_W;
    localparam int CCOL_W    = 12;
    localparam int LWIDTH_W  = 13;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam logic [1:0] MODE_MONO = 2'd0;
    localparam logic [1:0] MODE_420  = 2'd1;
    localparam logic [1:0] MODE_422  = 2'd2;
    localparam logic [1:0] MODE_444  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

    localparam logic [1:0]          MODE_RESET  = MODE_420;
    localparam logic [LWIDTH_W-1:0] WIDTH_RESET = 13'd1920;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PASS,
        OP_AVG2,
        OP_AVG4
    } chroma_op_t;

    typedef struct packed {
        logic [BYTE_W-1:0] y;
        chroma_op_t        op;
        logic [SUM_W-1:0]  su;
        logic [SUM_W-1:0]  sv;
        logic [CCOL_W-1:0] ccol;
    } cs420_stage_t;

endpackage

`default_nettype wire

// File: rtl/core/chroma_subsampler_444_to_420_unit.sv
// Input is registered in the staging register, then in the master-side output register.
// Throughput: one pixel per cycle unless the master side stalls; the line store has one
// write and one read port, a pair sum is written on even rows and read on odd rows.
// Reset: rst_n asynchronous active low; clears counters, held chroma, mode (4:2:0)
// and line width (1920). The line store is not cleared.
`default_nettype none

module chroma_subsampler_444_to_420_unit
    import cs420_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // y_in, u_in, v_in
    input  wire logic                  s_axis_tuser,  // frame_start
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // y_out, u_out, v_out, chroma_col, pad
    output logic                       m_axis_tuser,  // chroma_valid
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [LWIDTH_W-1:0]   cfg_data
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = $clog2(LINE_DEPTH);

    logic [1:0]          mode_reg;
    logic [LWIDTH_W-1:0] width_reg;
    logic                accept, advance, out_free;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_addr;
    logic [LINE_W-1:0]   mem_wdata, mem_rdata;
    cs420_stage_t        stage_reg;
    logic                stage_valid_reg;
    logic [BYTE_W-1:0]   y_reg, u_reg, v_reg;
    logic                cvalid_reg;
    logic [CCOL_W-1:0]   ccol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_WIDTH: width_reg <= cfg_data;
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign advance       = stage_valid_reg && out_free;
    assign s_axis_tready = !stage_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cs420_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .advance         (advance),
        .frame_start     (s_axis_tuser),
        .y_in            (s_axis_tdata[7:0]),
        .u_in            (s_axis_tdata[15:8]),
        .v_in            (s_axis_tdata[23:16]),
        .mode            (mode_reg),
        .line_width      (width_reg),
        .mem_we          (mem_we),
        .mem_re          (mem_re),
        .mem_addr        (mem_addr),
        .mem_wdata       (mem_wdata),
        .stage_reg       (stage_reg),
        .stage_valid_reg (stage_valid_reg)
    );

    cs420_line_mem #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    cs420_avg u_avg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .out_ready     (m_axis_tready),
        .stage         (stage_reg),
        .line_data     (mem_rdata),
        .out_valid_reg (m_axis_tvalid),
        .y_reg         (y_reg),
        .cvalid_reg    (cvalid_reg),
        .u_reg         (u_reg),
        .v_reg         (v_reg),
        .ccol_reg      (ccol_reg)
    );

    assign m_axis_tdata = {4'b0000, ccol_reg, v_reg, u_reg, y_reg};
    assign m_axis_tuser = cvalid_reg;

`ifndef NO_ASSERTIONS
    a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[35:8] == '0))
        else $error("chroma fields not cleared without a sample");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline full");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(stage_valid_reg))
        else $error("result appeared with no staged pixel");
`endif

endmodule

`default_nettype wire

// File: rtl/core/cs420_line_mem.sv
`default_nettype none

module cs420_line_mem
    import cs420_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [LINE_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [LINE_W-1:0] rdata
);

    logic [LINE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cs420_front.sv
`default_nettype none

module cs420_front
    import cs420_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic                advance,
    input  wire logic                frame_start,
    input  wire logic [BYTE_W-1:0]   y_in,
    input  wire logic [BYTE_W-1:0]   u_in,
    input  wire logic [BYTE_W-1:0]   v_in,
    input  wire logic [1:0]          mode,
    input  wire logic [LWIDTH_W-1:0] line_width,
    output logic                     mem_we,
    output logic                     mem_re,
    output logic [$clog2(MAX_WIDTH/2)-1:0] mem_addr,
    output logic [LINE_W-1:0]        mem_wdata,
    output cs420_stage_t             stage_reg,
    output logic                     stage_valid_reg
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = $clog2(MAX_WIDTH / 2);
    localparam int WW = (CW + 1 > LWIDTH_W) ? CW + 1 : LWIDTH_W;

    logic [CW-1:0]     col_reg, col_next, col_cur;
    logic              odd_reg, odd_next, odd_cur;
    logic [BYTE_W-1:0] held_u_reg, held_u_next, held_v_reg, held_v_next;
    logic [SUM_W-1:0]  pair_u, pair_v;
    logic [WW-1:0]     lw_ext, eff_width, col_inc;
    cs420_stage_t      stage_next;
    logic              stage_valid_next;

    always_comb
    begin
        lw_ext = WW'(line_width);
        if (lw_ext < WW'(2))
        begin
            eff_width = WW'(2);
        end
        else if (lw_ext > WW'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = lw_ext;
        end
    end

    always_comb
    begin
        col_cur = frame_start ? '0 : col_reg;
        odd_cur = frame_start ? 1'b0 : odd_reg;
        pair_u  = {1'b0, held_u_reg} + {1'b0, u_in};
        pair_v  = {1'b0, held_v_reg} + {1'b0, v_in};

        held_u_next = held_u_reg;
        held_v_next = held_v_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = col_cur[AW:1];
        mem_wdata   = {pair_v, pair_u};

        stage_next.y    = y_in;
        stage_next.op   = OP_NONE;
        stage_next.su   = pair_u;
        stage_next.sv   = pair_v;
        stage_next.ccol = CCOL_W'(col_cur >> 1);

        case (mode) inside
            MODE_444:
            begin
                stage_next.op   = OP_PASS;
                stage_next.su   = {1'b0, u_in};
                stage_next.sv   = {1'b0, v_in};
                stage_next.ccol = CCOL_W'(col_cur);
            end
            MODE_422, MODE_420:
            begin
                if (!col_cur[0])
                begin
                    held_u_next = u_in;
                    held_v_next = v_in;
                end
                else if (mode == MODE_422)
                begin
                    stage_next.op = OP_AVG2;
                end
                else if (!odd_cur)
                begin
                    mem_we = accept;
                end
                else
                begin
                    mem_re        = accept;
                    stage_next.op = OP_AVG4;
                end
            end
            default:
            begin
                stage_next.op = OP_NONE;
            end
        endcase

        col_inc = WW'(col_cur) + WW'(1);
        if (col_inc >= eff_width)
        begin
            col_next = '0;
            odd_next = ~odd_cur;
        end
        else
        begin
            col_next = CW'(col_inc);
            odd_next = odd_cur;
        end

        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            odd_reg         <= 1'b0;
            held_u_reg      <= '0;
            held_v_reg      <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (accept)
            begin
                col_reg    <= col_next;
                odd_reg    <= odd_next;
                held_u_reg <= held_u_next;
                held_v_reg <= held_v_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cs420_avg.sv
`default_nettype none

module cs420_avg
    import cs420_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic              out_ready,
    input  wire cs420_stage_t      stage,
    input  wire logic [LINE_W-1:0] line_data,
    output logic                   out_valid_reg,
    output logic [BYTE_W-1:0]      y_reg,
    output logic                   cvalid_reg,
    output logic [BYTE_W-1:0]      u_reg,
    output logic [BYTE_W-1:0]      v_reg,
    output logic [CCOL_W-1:0]      ccol_reg
);

    logic [SUM_W:0]    sum_u, sum_v;
    logic [BYTE_W-1:0] u_next, v_next;
    logic              cvalid_next;
    logic [CCOL_W-1:0] ccol_next;
    logic              out_valid_next;

    always_comb
    begin
        sum_u       = '0;
        sum_v       = '0;
        u_next      = '0;
        v_next      = '0;
        cvalid_next = 1'b1;
        ccol_next   = stage.ccol;
        case (stage.op)
            OP_PASS:
            begin
                u_next = stage.su[BYTE_W-1:0];
                v_next = stage.sv[BYTE_W-1:0];
            end
            OP_AVG2:
            begin
                sum_u  = {1'b0, stage.su} + (SUM_W+1)'(1);
                sum_v  = {1'b0, stage.sv} + (SUM_W+1)'(1);
                u_next = sum_u[BYTE_W:1];
                v_next = sum_v[BYTE_W:1];
            end
            OP_AVG4:
            begin
                sum_u  = {1'b0, stage.su} + {1'b0, line_data[SUM_W-1:0]} + (SUM_W+1)'(2);
                sum_v  = {1'b0, stage.sv} + {1'b0, line_data[LINE_W-1:SUM_W]}
                         + (SUM_W+1)'(2);
                u_next = sum_u[SUM_W:2];
                v_next = sum_v[SUM_W:2];
            end
            default:
            begin
                cvalid_next = 1'b0;
                ccol_next   = '0;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            y_reg      <= stage.y;
            cvalid_reg <= cvalid_next;
            u_reg      <= u_next;
            v_reg      <= v_next;
            ccol_reg   <= ccol_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
    import cs420_pkg::*;

    localparam int MAX_W          = 4096;
    localparam int LINE_DEPTH     = MAX_W / 2;
    localparam int LATENCY        = 2;
    localparam int HOLD_CYCLES    = 64;
    localparam int RANDOM_TARGET  = 1620;
    localparam int TIMEOUT        = 5_000_000;

    typedef struct packed {
        logic [BYTE_W-1:0] y;
        logic              chroma_ok;
        logic [BYTE_W-1:0] u;
        logic [BYTE_W-1:0] v;
        logic [CCOL_W-1:0] ccol;
    } pixel_out_t;

    class subsample_scoreboard;
        logic [1:0]          mode;
        logic [LWIDTH_W-1:0] line_width;
        int unsigned         column;
        bit                  odd_row;
        logic [BYTE_W-1:0]   held_u;
        logic [BYTE_W-1:0]   held_v;
        logic [LINE_W-1:0]   pair_sums [LINE_DEPTH];
        bit                  pair_seen [LINE_DEPTH];
        pixel_out_t          expected_q [$];
        int                  mismatches;

        function new();
            mode       = MODE_RESET;
            line_width = WIDTH_RESET;
            column     = 0;
            odd_row    = 1'b0;
            held_u     = '0;
            held_v     = '0;
            mismatches = 0;
            foreach (pair_seen[i])
                pair_seen[i] = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LWIDTH_W-1:0] data);
            if (idx == REG_MODE)
                mode = data[1:0];
            else
                line_width = data;
        endfunction

        function int unsigned row_length();
            if (line_width < 2)
                return 2;
            if (line_width > MAX_W)
                return MAX_W;
            return 32'(line_width);
        endfunction

        // true if this pixel would complete a 2x2 block from a line entry never stored
        function bit reads_blank_entry(bit fs);
            return !fs && mode == MODE_420 && odd_row && column[0] && !pair_seen[column >> 1];
        endfunction

        function void note_pixel(bit fs, logic [BYTE_W-1:0] y, logic [BYTE_W-1:0] u,
                                 logic [BYTE_W-1:0] v);
            pixel_out_t  exp_px;
            int unsigned su;
            int unsigned sv;
            int unsigned idx;
            if (fs)
            begin
                column  = 0;
                odd_row = 1'b0;
            end
            idx    = column >> 1;
            exp_px = '0;
            exp_px.y = y;
            case (mode) inside
                MODE_444:
                begin
                    exp_px.chroma_ok = 1'b1;
                    exp_px.u         = u;
                    exp_px.v         = v;
                    exp_px.ccol      = column[CCOL_W-1:0];
                end
                MODE_422, MODE_420:
                begin
                    if (!column[0])
                    begin
                        held_u = u;
                        held_v = v;
                    end
                    else
                    begin
                        su = 32'(held_u) + 32'(u);
                        sv = 32'(held_v) + 32'(v);
                        if (mode == MODE_422)
                        begin
                            exp_px.chroma_ok = 1'b1;
                            exp_px.u         = BYTE_W'((su + 1) >> 1);
                            exp_px.v         = BYTE_W'((sv + 1) >> 1);
                            exp_px.ccol      = CCOL_W'(column >> 1);
                        end
                        else if (!odd_row)
                        begin
                            pair_sums[idx] = {sv[SUM_W-1:0], su[SUM_W-1:0]};
                            pair_seen[idx] = 1'b1;
                        end
                        else
                        begin
                            su += 32'(pair_sums[idx][SUM_W-1:0]);
                            sv += 32'(pair_sums[idx][LINE_W-1:SUM_W]);
                            exp_px.chroma_ok = 1'b1;
                            exp_px.u         = BYTE_W'((su + 2) >> 2);
                            exp_px.v         = BYTE_W'((sv + 2) >> 2);
                            exp_px.ccol      = CCOL_W'(column >> 1);
                        end
                    end
                end
                default: ;
            endcase
            column++;
            if (column >= row_length())
            begin
                column  = 0;
                odd_row = !odd_row;
            end
            expected_q.push_back(exp_px);
        endfunction

        function void note_mismatch(string field, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(pixel_out_t got);
            pixel_out_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending: y=%0d chroma=%0b", got.y,
                             got.chroma_ok);
                return;
            end
            want = expected_q.pop_front();
            if (got.y !== want.y)
                note_mismatch("y_out", want.y, got.y);
            if (got.chroma_ok !== want.chroma_ok)
                note_mismatch("chroma_valid", want.chroma_ok, got.chroma_ok);
            if (got.u !== want.u)
                note_mismatch("u_out", want.u, got.u);
            if (got.v !== want.v)
                note_mismatch("v_out", want.v, got.v);
            if (got.ccol !== want.ccol)
                note_mismatch("chroma_col", want.ccol, got.ccol);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [LWIDTH_W-1:0]   cfg_data;

    subsample_scoreboard sb;
    bit                  sender_calm;
    bit                  sink_calm;
    bit                  hold_pending;
    int                  pixels_sent;

    chroma_subsampler_444_to_420_unit #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LWIDTH_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic configure(logic [1:0] mode, logic [LWIDTH_W-1:0] width);
        write_reg(REG_MODE, LWIDTH_W'(mode));
        write_reg(REG_WIDTH, width);
    endtask

    task automatic send_pixel(bit fs, logic [BYTE_W-1:0] y, logic [BYTE_W-1:0] u,
                              logic [BYTE_W-1:0] v);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, 3);
        if (sb.reads_blank_entry(fs))
            fs = 1'b1;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, u, y};
        s_axis_tuser  <= fs;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pixel(fs, y, u, v);
        pixels_sent++;
    endtask

    // drop valid, let every pending result drain, then settle the pipeline
    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // sink: random stall per transaction, optional long hold-off
    initial
    begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = sink_calm ? 0 : $urandom_range(0, 3);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall += HOLD_CYCLES;
            end
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        pixel_out_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.y         = m_axis_tdata[7:0];
            got.chroma_ok = m_axis_tuser;
            got.u         = m_axis_tdata[15:8];
            got.v         = m_axis_tdata[23:16];
            got.ccol      = m_axis_tdata[35:24];
            sb.check_result(got);
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("** chroma_subsampler_444_to_420_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int unsigned     sel;
        int unsigned     phase;
        int unsigned     burst_len;
        bit              start_fs;
        bit              fs;
        logic [1:0]      new_mode;
        logic [LWIDTH_W-1:0] width;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_MODE;
        cfg_data      = '0;
        sender_calm   = 1'b0;
        sink_calm     = 1'b0;
        hold_pending  = 1'b0;
        pixels_sent   = 0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 4:2:0 on two-pixel rows, saturated and zero chroma
        configure(MODE_420, 13'd2);
        send_pixel(1'b1, 8'h00, 8'hFF, 8'h00);
        send_pixel(1'b0, 8'hFF, 8'hFF, 8'h00);
        send_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
        send_pixel(1'b0, 8'hFF, 8'hFF, 8'h01);
        send_pixel(1'b0, 8'h80, 8'h00, 8'hFF);
        send_pixel(1'b0, 8'h7F, 8'h00, 8'hFF);
        send_pixel(1'b0, 8'h01, 8'h00, 8'hFF);
        send_pixel(1'b0, 8'hFE, 8'h01, 8'hFE);
        end_burst();

        // 4:2:2 with odd width: trailing pixel gives no chroma
        configure(MODE_422, 13'd3);
        send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(1'b0, 8'h00, 8'hFF, 8'hFE);
        send_pixel(1'b0, 8'hFF, 8'h12, 8'h34);
        send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
        send_pixel(1'b0, 8'h55, 8'h01, 8'h00);
        end_burst();

        // width below range acts as 2
        configure(MODE_444, 13'd0);
        send_pixel(1'b0, 8'hAA, 8'h00, 8'hFF);
        send_pixel(1'b0, 8'h55, 8'hFF, 8'h00);
        end_burst();

        // width above range clamps
        configure(MODE_MONO, 13'h1FFF);
        send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
        end_burst();

        // mode switch mid-row, no frame start
        write_reg(REG_MODE, LWIDTH_W'(MODE_420));
        send_pixel(1'b0, 8'h3C, 8'hC3, 8'h5A);
        send_pixel(1'b0, 8'hC3, 8'h3C, 8'hA5);
        end_burst();

        phase = 0;
        while (pixels_sent < RANDOM_TARGET)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            sink_calm   = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                new_mode = MODE_MONO;
            else if (sel < 3)
                new_mode = MODE_444;
            else if (sel < 5)
                new_mode = MODE_422;
            else
                new_mode = MODE_420;
            write_reg(REG_MODE, LWIDTH_W'(new_mode));

            sel = $urandom_range(0, 15);
            if (sel < 6)
                width = LWIDTH_W'(2 * $urandom_range(1, 8));
            else if (sel < 8)
                width = LWIDTH_W'(2 * $urandom_range(1, 7) + 1);
            else if (sel == 8)
                width = LWIDTH_W'($urandom_range(0, 1));
            else if (sel == 9)
                width = LWIDTH_W'($urandom_range(17, 300));
            else if (sel == 10)
            begin
                case ($urandom_range(0, 2))
                    0:       width = 13'd4096;
                    1:       width = 13'h1FFF;
                    default: width = LWIDTH_W'($urandom_range(4097, 8190));
                endcase
            end
            if (sel <= 10)
                write_reg(REG_WIDTH, width);

            // back-pressure: sink holds off while the source keeps pushing
            if (phase == 2)
            begin
                sender_calm  = 1'b1;
                sink_calm    = 1'b0;
                hold_pending = 1'b1;
            end

            burst_len = $urandom_range(30, 70);
            start_fs  = ($urandom_range(0, 1) == 1);
            for (int i = 0; i < burst_len; i++)
            begin
                fs = (i == 0 && start_fs) || ($urandom_range(0, 59) == 0);
                send_pixel(fs, pick_byte(), pick_byte(), pick_byte());
            end
            end_burst();
            phase++;
        end

        sender_calm = 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 6) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("** chroma_subsampler_444_to_420_unit: PASSED **");
        else
            $display("** chroma_subsampler_444_to_420_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
